// ===== rtl/shp_pkg.sv =====
`timescale 1ns / 1ps

package shp_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int PIX_W       = 16;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WCFG_W      = 11;
	localparam int HGT_W       = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_W       = 20;
	localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam int WIDTH_RESET  = 512;
	localparam int HEIGHT_RESET = 512;
	localparam int MIN_SIZE     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             last;
	} out_item_t;

endpackage

// ===== rtl/sharpen_3x3_convolution_top.sv =====
`timescale 1ns / 1ps
// channel   | valid/ready                  | payload
// ----------+------------------------------+---------------------------------------
// s_axis    | s_axis_tvalid/s_axis_tready  | tdata: pixel_value, tuser: command
// m_axis    | m_axis_tvalid/m_axis_tready  | tdata: filtered_value, tlast: frame_last
// cfg       | cfg_wen (no ready)           | cfg_addr, cfg_wdata
//
// One request per clock while s_axis_tready is high.
// The rate is set by the single-port line buffers, read and written once per request.
// s_axis_tready drops only while both output slots (register and skid) are full.
// arst_n clears counters and valid flags; line buffer contents stay undefined.
// A config write restarts the frame.

module sharpen_3x3_convolution_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [shp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] pixel_value
	input  logic [0:0]                        s_axis_tuser,  // [0] command
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [shp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [19:0] filtered_value, zero pad
	output logic                              m_axis_tlast,
	input  logic                              cfg_wen,
	input  logic [shp_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [shp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import shp_pkg::*;

	logic [COL_W-1:0] wm1_q;
	logic [HGT_W-1:0] h_q;
	logic [HGT_W-1:0] hm1_q;
	logic [COL_W-1:0] col_q;
	logic [HGT_W-1:0] row_q;
	logic [COL_W-1:0] ocol_q;
	logic [HGT_W-1:0] orow_q;

	logic [WCFG_W-1:0] w_raw;
	logic [WCFG_W-1:0] w_clamp;
	logic [HGT_W-1:0]  h_clamp;

	logic en, accept, frame_full, adv, wr_pix, emit, border, last;
	logic [PIX_W-1:0] pix;

	logic             v_s1, e_s1, bd_s1, lst_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             e_s2, bd_s2, lst_s2;
	logic             e_s3, bd_s3, lst_s3;
	logic [OUT_W-1:0] centre_s3, suma_s3, sumb_s3;

	logic [PIX_W-1:0] lb1_rd, lb2_rd;
	logic [PIX_W-1:0] b0, b1, m0, m1, m2, t1;
	logic             win_shift;
	logic             push, buf_full;
	out_item_t        push_item, out_item;

	assign en         = !buf_full;
	assign accept     = s_axis_tvalid && en;
	assign frame_full = (row_q == h_q);
	assign adv        = accept && (frame_full || s_axis_tuser[0] == CMD_PIXEL);
	assign wr_pix     = accept && !frame_full && s_axis_tuser[0] == CMD_PIXEL;
	assign pix        = s_axis_tdata[PIX_W-1:0];
	assign emit       = adv && (row_q > HGT_W'(1) || (row_q == HGT_W'(1) && col_q != '0));
	assign border     = orow_q == '0 || orow_q == hm1_q || ocol_q == '0 || ocol_q == wm1_q;
	assign last       = orow_q == hm1_q && ocol_q == wm1_q;

	always_comb begin
		w_raw = cfg_wdata[WCFG_W-1:0];
		if (w_raw < WCFG_W'(MIN_SIZE)) begin
			w_clamp = WCFG_W'(MIN_SIZE);
		end else if (w_raw > WCFG_W'(MAX_WIDTH)) begin
			w_clamp = WCFG_W'(MAX_WIDTH);
		end else begin
			w_clamp = w_raw;
		end
		if (cfg_wdata[HGT_W-1:0] < HGT_W'(MIN_SIZE)) begin
			h_clamp = HGT_W'(MIN_SIZE);
		end else begin
			h_clamp = cfg_wdata[HGT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q  <= COL_W'(WIDTH_RESET - 1);
			h_q    <= HGT_W'(HEIGHT_RESET);
			hm1_q  <= HGT_W'(HEIGHT_RESET - 1);
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_WIDTH: begin
					wm1_q <= COL_W'(w_clamp - WCFG_W'(1));
				end
				CFG_HEIGHT: begin
					h_q   <= h_clamp;
					hm1_q <= h_clamp - HGT_W'(1);
				end
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (emit && last) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else begin
			if (adv) begin
				if (col_q == wm1_q) begin
					col_q <= '0;
					if (!frame_full) begin
						row_q <= row_q + HGT_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (emit) begin
				if (ocol_q == wm1_q) begin
					ocol_q <= '0;
					orow_q <= orow_q + HGT_W'(1);
				end else begin
					ocol_q <= ocol_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			e_s1   <= 1'b0;
			bd_s1  <= 1'b0;
			lst_s1 <= 1'b0;
			e_s2   <= 1'b0;
			bd_s2  <= 1'b0;
			lst_s2 <= 1'b0;
			e_s3   <= 1'b0;
			bd_s3  <= 1'b0;
			lst_s3 <= 1'b0;
		end else if (en) begin
			v_s1   <= adv;
			e_s1   <= emit;
			bd_s1  <= border;
			lst_s1 <= last;
			e_s2   <= e_s1;
			bd_s2  <= bd_s1;
			lst_s2 <= lst_s1;
			e_s3   <= e_s2;
			bd_s3  <= bd_s2;
			lst_s3 <= lst_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1    <= pix;
			col_s1    <= col_q;
			centre_s3 <= OUT_W'(m1);
			suma_s3   <= OUT_W'({m1, 2'b00}) + OUT_W'(m1) - OUT_W'(m0) - OUT_W'(m2);
			sumb_s3   <= OUT_W'(t1) + OUT_W'(b1);
		end
	end

	shp_line u_lb1 (
		.clk   (clk),
		.rd_en (adv),
		.wr_en (wr_pix),
		.addr  (col_q),
		.wdata (pix),
		.rdata (lb1_rd)
	);

	shp_line u_lb2 (
		.clk   (clk),
		.rd_en (win_shift),
		.wr_en (win_shift),
		.addr  (col_s1),
		.wdata (lb1_rd),
		.rdata (lb2_rd)
	);

	// window: bottom row b0,b1; middle m0..m2; top row lb2_rd,t1
	assign win_shift = en && v_s1;

	shp_cell u_b0 (.clk(clk), .shift(win_shift), .din(pix_s1), .dout(b0));
	shp_cell u_b1 (.clk(clk), .shift(win_shift), .din(b0),     .dout(b1));
	shp_cell u_m0 (.clk(clk), .shift(win_shift), .din(lb1_rd), .dout(m0));
	shp_cell u_m1 (.clk(clk), .shift(win_shift), .din(m0),     .dout(m1));
	shp_cell u_m2 (.clk(clk), .shift(win_shift), .din(m1),     .dout(m2));
	shp_cell u_t1 (.clk(clk), .shift(win_shift), .din(lb2_rd), .dout(t1));

	assign push            = en && e_s3;
	assign push_item.value = bd_s3 ? centre_s3 : (suma_s3 - sumb_s3);
	assign push_item.last  = lst_s3;

	shp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_item  (out_item),
		.full      (buf_full)
	);

	assign s_axis_tready = en;
	assign m_axis_tdata  = OUT_TDATA_W'(out_item.value);
	assign m_axis_tlast  = out_item.last;

endmodule

// ===== rtl/shp_cell.sv =====
`timescale 1ns / 1ps

module shp_cell (
	input  logic                      clk,
	input  logic                      shift,
	input  logic [shp_pkg::PIX_W-1:0] din,
	output logic [shp_pkg::PIX_W-1:0] dout
);
	import shp_pkg::*;

	logic [PIX_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			pix_q <= din;
		end
	end

	assign dout = pix_q;

endmodule

// ===== rtl/shp_line.sv =====
`timescale 1ns / 1ps

module shp_line (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic                      wr_en,
	input  logic [shp_pkg::COL_W-1:0] addr,
	input  logic [shp_pkg::PIX_W-1:0] wdata,
	output logic [shp_pkg::PIX_W-1:0] rdata
);
	import shp_pkg::*;

	logic [PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_q;

	// read returns the value from one line ago, then the slot is overwritten
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_q;

endmodule

// ===== rtl/shp_outbuf.sv =====
`timescale 1ns / 1ps

module shp_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  shp_pkg::out_item_t push_item,
	input  logic               pop_ready,
	output logic               out_valid,
	output shp_pkg::out_item_t out_item,
	output logic               full
);
	import shp_pkg::*;

	logic      out_v_q;
	logic      skid_v_q;
	out_item_t out_q;
	out_item_t skid_q;
	logic      pop;

	assign pop = out_v_q && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			case ({push, pop})
				2'b10: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
					end else begin
						skid_v_q <= 1'b1;
					end
				end
				2'b01: begin
					if (skid_v_q) begin
						skid_v_q <= 1'b0;
					end else begin
						out_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (!out_v_q) begin
					out_q <= push_item;
				end else begin
					skid_q <= push_item;
				end
			end
			2'b01: begin
				if (skid_v_q) begin
					out_q <= skid_q;
				end
			end
			2'b11: begin
				if (skid_v_q) begin
					out_q  <= skid_q;
					skid_q <= push_item;
				end else begin
					out_q <= push_item;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;
	assign full      = out_v_q && skid_v_q;

endmodule

// ===== rtl/shp_check.sv =====
`timescale 1ns / 1ps

module shp_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [shp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic                              m_axis_tlast
);
	import shp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output buffer");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && !m_axis_tready |=> !s_axis_tready)
		else $error("buffer left full state without a pop");

endmodule

bind sharpen_3x3_convolution_top shp_check u_shp_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import shp_pkg::*;

	localparam int unsigned RING_N = 2 * MAX_WIDTH + 2;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pix;
	} pixel_req_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [15:0] pixel_value
	logic [0:0]             s_axis_tuser = '0;  // [0] command
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [19:0] filtered_value, zero pad above
	logic                   m_axis_tlast;
	logic                   cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	sharpen_3x3_convolution_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #10 clk = ~clk;

	// stimulus and scoreboard state
	pixel_req_t  pixel_req_q[$];
	pixel_req_t  drv_next;
	out_item_t   sharpened_q[$];
	out_item_t   due_res;
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned frame_cnt = 0;
	int unsigned reg_writes = 0;
	int unsigned err_cnt = 0;
	int unsigned stim_work = 0;
	int unsigned send_idle = 22;
	int unsigned recv_idle = 88;
	bit          pause_due = 1'b0;

	// sharpen predictor state
	logic [PIX_W-1:0] ring_mem [RING_N];
	int unsigned width_reg = WIDTH_RESET;
	int unsigned height_reg = HEIGHT_RESET;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned emitted = 0;

	function automatic int unsigned cols_eff();
		if (width_reg < MIN_SIZE)
			return MIN_SIZE;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned rows_eff();
		return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
	endfunction

	task automatic sharpen_restart();
		col_pos = 0;
		row_pos = 0;
		emitted = 0;
	endtask

	task automatic sharpen_emit(int unsigned w, int unsigned h);
		int unsigned q, r, c;
		int          acc;
		out_item_t   res;
		q = emitted;
		r = q / w;
		c = q % w;
		if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
			acc = int'(ring_mem[q % RING_N]);
		end else begin
			acc = 5 * int'(ring_mem[q % RING_N])
				- int'(ring_mem[(q - w) % RING_N]) - int'(ring_mem[(q + w) % RING_N])
				- int'(ring_mem[(q - 1) % RING_N]) - int'(ring_mem[(q + 1) % RING_N]);
		end
		res.value = acc[OUT_W-1:0];
		emitted = q + 1;
		res.last = (emitted >= w * h);
		if (res.last)
			sharpen_restart();
		sharpened_q.push_back(res);
	endtask

	task automatic sharpen_accept(logic cmd, logic [PIX_W-1:0] pix);
		int unsigned w, h, p;
		w = cols_eff();
		h = rows_eff();
		if (col_pos >= w || row_pos > h)
			sharpen_restart();
		if (cmd == CMD_PIXEL && row_pos < h) begin
			p = row_pos * w + col_pos;
			ring_mem[p % RING_N] = pix;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (p >= w + 1 && emitted == p - w - 1)
				sharpen_emit(w, h);
		end else if (row_pos >= h && emitted < w * h) begin
			sharpen_emit(w, h);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				sharpen_accept(s_axis_tuser[0], s_axis_tdata[PIX_W-1:0]);
				accepted_cnt++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					drv_next = pixel_req_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= drv_next.pix;
					s_axis_tuser <= drv_next.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_cnt++;
				if (m_axis_tlast)
					frame_cnt++;
				if (sharpened_q.size() == 0) begin
					if (err_cnt < 40)
						$error("unexpected result: filtered_value %0d frame_last %0b",
							$signed(m_axis_tdata[OUT_W-1:0]), m_axis_tlast);
					err_cnt++;
				end else begin
					due_res = sharpened_q.pop_front();
					if (m_axis_tdata[OUT_W-1:0] !== due_res.value) begin
						if (err_cnt < 40)
							$error("filtered_value: expected %0d, got %0d",
								$signed(due_res.value), $signed(m_axis_tdata[OUT_W-1:0]));
						err_cnt++;
					end
					if (m_axis_tlast !== due_res.last) begin
						if (err_cnt < 40)
							$error("frame_last: expected %0b, got %0b", due_res.last, m_axis_tlast);
						err_cnt++;
					end
					if (m_axis_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
						if (err_cnt < 40)
							$error("tdata pad: expected 0, got %0h",
								m_axis_tdata[OUT_TDATA_W-1:OUT_W]);
						err_cnt++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic push_req(logic cmd, logic [PIX_W-1:0] pix);
		pixel_req_q.push_back('{cmd: cmd, pix: pix});
		queued_cnt++;
	endtask

	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || sharpened_q.size() != 0)
			@(negedge clk);
	endtask

	// quiet period so nothing is still in flight when a register changes
	task automatic settle();
		wait_drained();
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		if (idx == CFG_WIDTH)
			width_reg = data & 16'h07FF;
		else
			height_reg = data;
		sharpen_restart();
		reg_writes++;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// cut < width*height aborts the frame after cut pixels
	task automatic send_frame(int unsigned cut);
		int unsigned cols, total;
		cols = cols_eff();
		total = cols * rows_eff();
		for (int unsigned p = 0; p < cut; p++) begin
			if ($urandom_range(24) == 0)
				push_req(CMD_FLUSH, PIX_W'($urandom));
			if (pause_due && p == total / 2) begin
				pause_due = 1'b0;
				wait_drained();
			end
			push_req(CMD_PIXEL, rand_pixel());
		end
		stim_work += cut;
		if (cut == total) begin
			// drain the last width+1 results with a mix of flushes and surplus pixels
			for (int unsigned k = 0; k <= cols; k++)
				push_req($urandom_range(1) ? CMD_FLUSH : CMD_PIXEL, PIX_W'($urandom));
			stim_work += cols + 1;
			if ($urandom_range(4) == 0)
				push_req(CMD_FLUSH, PIX_W'($urandom));
		end
	endtask

	logic [PIX_W-1:0] extreme_px [12] = '{
		16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
		16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
		16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000
	};

	initial begin
		int unsigned w, h, n, cut, total;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// power-on geometry, part of a frame, then abandoned by the first write
		repeat (64) push_req(CMD_PIXEL, rand_pixel());
		settle();

		// 4x3 frame (height 2 clamps to 3) hitting both output extremes
		write_reg(CFG_WIDTH, 16'd4);
		write_reg(CFG_HEIGHT, 16'd2);
		foreach (extreme_px[i]) begin
			push_req(CMD_PIXEL, extreme_px[i]);
			if (i == 5)
				push_req(CMD_FLUSH, 16'hFFFF);
		end
		push_req(CMD_FLUSH, 16'h0000);
		push_req(CMD_PIXEL, 16'h1234);
		push_req(CMD_FLUSH, 16'hA5A5);
		push_req(CMD_PIXEL, 16'hFFFF);
		push_req(CMD_FLUSH, 16'h0000);
		push_req(CMD_FLUSH, 16'h5A5A);

		pause_due = 1'b1;
		while (stim_work < 500) begin
			if (stim_work >= 333) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (stim_work >= 167) begin
				send_idle = 88;
				recv_idle = 22;
			end
			settle();
			case ($urandom_range(9))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(9, 16);
				2: w = ($urandom_range(1, 31) << 11) | $urandom_range(3, 8);
				default: w = $urandom_range(3, 8);
			endcase
			write_reg(CFG_WIDTH, w[15:0]);
			if ($urandom_range(3) != 0) begin
				case ($urandom_range(9))
					0, 1: h = $urandom_range(0, 2);
					2: h = $urandom_range(7, 12);
					default: h = $urandom_range(3, 6);
				endcase
				write_reg(CFG_HEIGHT, h[15:0]);
			end
			n = $urandom_range(1, 3);
			for (int f = 0; f < n; f++) begin
				total = cols_eff() * rows_eff();
				cut = total;
				if (f == n - 1 && $urandom_range(7) == 0)
					cut = $urandom_range(1, total - 1);
				send_frame(cut);
			end
		end

		// clamped widest row, then the tallest frame, both cut short
		settle();
		write_reg(CFG_WIDTH, 16'd2047);
		write_reg(CFG_HEIGHT, 16'hFFFF);
		send_frame(40);
		settle();
		write_reg(CFG_WIDTH, 16'd3);
		send_frame(45);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Run: %0d requests, %0d results checked, %0d complete frames, %0d register writes.",
			accepted_cnt, result_cnt, frame_cnt, reg_writes);
		$display("Widths 3 to 16, clamped sizes up to 1024 wide and 65535 tall, flushes, aborts, stalls.");
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d of %0d requests accepted, %0d results pending.",
			accepted_cnt, queued_cnt, sharpened_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/shp_pkg.sv
rtl/shp_cell.sv
rtl/shp_line.sv
rtl/shp_outbuf.sv
rtl/sharpen_3x3_convolution_top.sv
rtl/shp_check.sv
dv/tb.sv
